@@ rtl/core/xvbr_pkg.sv @@
// Shared types and constants of the Xing VBR header parser and seek block.
`default_nettype none

package xvbr_pkg;

    localparam int TOC_ENTRIES = 100;
    localparam int TOC_AW      = $clog2(TOC_ENTRIES);

    localparam logic [TOC_AW-1:0] TOC_LAST = TOC_AW'(TOC_ENTRIES - 1);
    localparam logic [14:0]       SEEK_MAX = 15'(TOC_ENTRIES * 256);
    localparam logic [8:0]        FB_END   = 9'd256;

    localparam logic [5:0] SKIP_LONG  = 6'd32;
    localparam logic [5:0] SKIP_MID   = 6'd17;
    localparam logic [5:0] SKIP_SHORT = 6'd9;
    localparam logic [1:0] MODE_MONO  = 2'd3;

    localparam logic [7:0] TAG_CHARS [4] = '{8'h58, 8'h69, 8'h6E, 8'h67};

    localparam logic RESULT_VERDICT = 1'b0;
    localparam logic RESULT_SEEK    = 1'b1;

    typedef logic [7:0] toc_tab_t [TOC_ENTRIES];

    function automatic toc_tab_t lin_toc_build();
        toc_tab_t t;
        for (int k = 0; k < TOC_ENTRIES; k++)
        begin
            t[k] = 8'((k * 256) / TOC_ENTRIES);
        end
        return t;
    endfunction

    // Table used when the header carries no table of contents.
    localparam toc_tab_t LIN_TOC = lin_toc_build();

    typedef struct packed {
        logic restart;
        logic pos_inc;
        logic pos_clr;
        logic cap_mpeg1;
        logic cap_mode;
        logic cap_flags;
        logic shift_frames;
        logic shift_bytes;
        logic toc_write;
        logic fin;
        logic fin_ok;
        logic seek_start;
        logic seek_fa;
        logic seek_fx;
        logic seek_done;
    } cmd_t;

    typedef struct packed {
        logic pos_is1;
        logic pos_is3;
        logic skip_last;
        logic toc_last;
        logic tag_match;
        logic frames_bad;
        logic toc_drop;
        logic byte_zero;
        logic byte_bit0;
        logic want_bytes;
        logic want_toc;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/xing_vbr_header_parse_and_seek.sv @@
// Top level of the Xing VBR header parser with table-of-contents seek.
//
//  Channel   Handshake             Payload
//  input     start, busy           action, frame_start, data_byte, seek_percent
//  result    done (one-cycle)      result_kind, header_ok, frame_count,
//                                  stream_bytes, seek_offset
//
// When a header byte ends the parse, its verdict shows on done in the following
// cycle while the next transaction is taken. A seek makes two table reads through
// the single read port of the store, then the interpolation multiply and the
// byte-offset multiply; busy is high until the seek answer is registered.
// Reset clears the parse and the held header; the table store is not cleared.
// The receiver cannot stall, so each result stands for exactly one cycle.
`default_nettype none

module xing_vbr_header_parse_and_seek (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic        frame_start,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] seek_percent,
    output logic             done,
    output logic             result_kind,
    output logic             header_ok,
    output logic [30:0]      frame_count,
    output logic [31:0]      stream_bytes,
    output logic [31:0]      seek_offset
);

    import xvbr_pkg::*;

    cmd_t    cmd;
    status_t st;

    xvbr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .frame_start (frame_start),
        .st          (st),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done)
    );

    xvbr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (data_byte),
        .seek_percent (seek_percent),
        .st           (st),
        .result_kind  (result_kind),
        .header_ok    (header_ok),
        .frame_count  (frame_count),
        .stream_bytes (stream_bytes),
        .seek_offset  (seek_offset)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a seek is in flight");

    a_seek_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action) |-> ##4 (done && result_kind == RESULT_SEEK))
        else $error("seek answer did not arrive four cycles after its transaction");

    a_ok_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
        (done && header_ok) |-> (frame_count != 31'd0))
        else $error("valid header reported with a zero frame count");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !header_ok) |-> (seek_offset == 32'd0 && stream_bytes == 32'd0))
        else $error("nonzero payload reported without a valid header");

endmodule

`default_nettype wire

@@ rtl/core/xvbr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module xvbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 100,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/xvbr_ctrl.sv @@
// Controller: header parse state machine and seek sequencer.
`default_nettype none

module xvbr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              action,
    input  wire logic              frame_start,
    input  wire xvbr_pkg::status_t st,
    output xvbr_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);

    import xvbr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_SKIP,
        PH_TAG,
        PH_FLAGS,
        PH_FRAMES,
        PH_BYTES,
        PH_TOC
    } phase_t;

    typedef enum logic [1:0] {
        SK_IDLE,
        SK_FA,
        SK_FX,
        SK_MUL
    } seek_t;

    phase_t phase_reg, phase_next, phase_eff;
    seek_t  seek_reg, seek_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        seek_next  = seek_reg;
        phase_eff  = frame_start ? PH_HDR : phase_reg;
        unique case (seek_reg)
            SK_IDLE:
            begin
                if (start && action)
                begin
                    cmd.seek_start = 1'b1;
                    seek_next      = SK_FA;
                end
                else if (start)
                begin
                    cmd.restart = frame_start;
                    phase_next  = phase_eff;
                    unique case (phase_eff)
                        PH_IDLE:
                        begin
                        end
                        PH_HDR:
                        begin
                            cmd.cap_mpeg1 = st.pos_is1;
                            cmd.cap_mode  = st.pos_is3;
                            if (st.pos_is3)
                            begin
                                phase_next  = PH_SKIP;
                                cmd.pos_clr = 1'b1;
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        PH_SKIP:
                        begin
                            if (st.skip_last)
                            begin
                                phase_next  = PH_TAG;
                                cmd.pos_clr = 1'b1;
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        PH_TAG:
                        begin
                            if (!st.tag_match)
                            begin
                                cmd.fin     = 1'b1;
                                cmd.pos_clr = 1'b1;
                                phase_next  = PH_IDLE;
                            end
                            else if (st.pos_is3)
                            begin
                                phase_next  = PH_FLAGS;
                                cmd.pos_clr = 1'b1;
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        PH_FLAGS:
                        begin
                            if (st.pos_is3)
                            begin
                                cmd.cap_flags = 1'b1;
                                cmd.pos_clr   = 1'b1;
                                if (st.byte_bit0)
                                begin
                                    phase_next = PH_FRAMES;
                                end
                                else
                                begin
                                    cmd.fin    = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        PH_FRAMES:
                        begin
                            cmd.shift_frames = 1'b1;
                            if (st.pos_is3)
                            begin
                                cmd.pos_clr = 1'b1;
                                priority if (st.frames_bad)
                                begin
                                    cmd.fin    = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else if (st.want_bytes)
                                begin
                                    phase_next = PH_BYTES;
                                end
                                else if (st.want_toc)
                                begin
                                    phase_next = PH_TOC;
                                end
                                else
                                begin
                                    cmd.fin    = 1'b1;
                                    cmd.fin_ok = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        PH_BYTES:
                        begin
                            cmd.shift_bytes = 1'b1;
                            if (st.pos_is3)
                            begin
                                cmd.pos_clr = 1'b1;
                                if (st.want_toc)
                                begin
                                    phase_next = PH_TOC;
                                end
                                else
                                begin
                                    cmd.fin    = 1'b1;
                                    cmd.fin_ok = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        PH_TOC:
                        begin
                            cmd.toc_write = 1'b1;
                            priority if (st.toc_drop)
                            begin
                                cmd.fin     = 1'b1;
                                cmd.pos_clr = 1'b1;
                                phase_next  = PH_IDLE;
                            end
                            else if (st.toc_last)
                            begin
                                cmd.fin     = 1'b1;
                                cmd.fin_ok  = !st.byte_zero;
                                cmd.pos_clr = 1'b1;
                                phase_next  = PH_IDLE;
                            end
                            else
                            begin
                                cmd.pos_inc = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SK_FA:
            begin
                cmd.seek_fa = 1'b1;
                seek_next   = SK_FX;
            end
            SK_FX:
            begin
                cmd.seek_fx = 1'b1;
                seek_next   = SK_MUL;
            end
            SK_MUL:
            begin
                cmd.seek_done = 1'b1;
                seek_next     = SK_IDLE;
            end
            default:
            begin
                seek_next = SK_IDLE;
            end
        endcase
        done_next = cmd.fin || cmd.seek_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            seek_reg  <= SK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            seek_reg  <= seek_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (seek_reg != SK_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/xvbr_dp.sv @@
// Datapath: parse registers, table store, seek interpolation and result registers.
`default_nettype none

module xvbr_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire xvbr_pkg::cmd_t cmd,
    input  wire logic [7:0]     data_byte,
    input  wire logic [15:0]    seek_percent,
    output xvbr_pkg::status_t   st,
    output logic                result_kind,
    output logic                header_ok,
    output logic [30:0]         frame_count,
    output logic [31:0]         stream_bytes,
    output logic [31:0]         seek_offset
);

    import xvbr_pkg::*;

    logic [TOC_AW-1:0] pos_reg, pos_next, pos_eff;
    logic              mpeg1_reg, mpeg1_next;
    logic [1:0]        mode_reg, mode_next;
    logic [2:0]        flags_reg, flags_next;
    logic              valid_reg, valid_next;
    logic [31:0]       frames_reg, frames_next;
    logic [31:0]       bytes_reg, bytes_next;
    logic [7:0]        prev_toc_reg;
    logic [5:0]        skip_len;

    logic [TOC_AW-1:0] a_reg, a_in, a_nxt, ram_raddr;
    logic [8:0]        f_reg, f_in;
    logic [14:0]       p_clamp;
    logic [7:0]        fa_reg, fa_sel;
    logic [8:0]        fb_sel, diff;
    logic [17:0]       part;
    logic [17:0]       fx_sum;
    logic [16:0]       fx_reg;
    logic [48:0]       big;
    logic [7:0]        ram_rdata;

    logic              kind_reg, ok_reg;
    logic [30:0]       fcount_reg;
    logic [31:0]       sbytes_reg, offset_reg;

    assign pos_eff = cmd.restart ? '0 : pos_reg;

    always_comb
    begin
        if (mpeg1_reg)
        begin
            skip_len = (mode_reg != MODE_MONO) ? SKIP_LONG : SKIP_MID;
        end
        else
        begin
            skip_len = (mode_reg != MODE_MONO) ? SKIP_MID : SKIP_SHORT;
        end
    end

    always_comb
    begin
        st            = '0;
        st.pos_is1    = (pos_eff == TOC_AW'(1));
        st.pos_is3    = (pos_eff == TOC_AW'(3));
        st.skip_last  = ({1'b0, pos_eff} == 8'(skip_len - 6'd1));
        st.toc_last   = (pos_eff == TOC_LAST);
        st.tag_match  = (data_byte == TAG_CHARS[pos_eff[1:0]]);
        st.frames_bad = ({frames_reg[23:0], data_byte} == 32'd0) || frames_reg[23];
        st.toc_drop   = (pos_eff != '0) && (data_byte < prev_toc_reg);
        st.byte_zero  = (data_byte == 8'd0);
        st.byte_bit0  = data_byte[0];
        st.want_bytes = flags_reg[1];
        st.want_toc   = flags_reg[2];
    end

    always_comb
    begin
        pos_next    = pos_reg;
        mpeg1_next  = mpeg1_reg;
        mode_next   = mode_reg;
        flags_next  = flags_reg;
        valid_next  = valid_reg;
        frames_next = frames_reg;
        bytes_next  = bytes_reg;
        if (cmd.restart)
        begin
            pos_next    = '0;
            flags_next  = '0;
            valid_next  = 1'b0;
            frames_next = '0;
            bytes_next  = '0;
        end
        priority if (cmd.pos_clr)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_eff + TOC_AW'(1);
        end
        if (cmd.cap_mpeg1)
        begin
            mpeg1_next = data_byte[3];
        end
        if (cmd.cap_mode)
        begin
            mode_next = data_byte[7:6];
        end
        if (cmd.cap_flags)
        begin
            flags_next = data_byte[2:0];
        end
        if (cmd.shift_frames)
        begin
            frames_next = {frames_reg[23:0], data_byte};
        end
        if (cmd.shift_bytes)
        begin
            bytes_next = {bytes_reg[23:0], data_byte};
        end
        if (cmd.fin)
        begin
            valid_next = cmd.fin_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            mpeg1_reg  <= 1'b0;
            mode_reg   <= '0;
            flags_reg  <= '0;
            valid_reg  <= 1'b0;
            frames_reg <= '0;
            bytes_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            mpeg1_reg  <= mpeg1_next;
            mode_reg   <= mode_next;
            flags_reg  <= flags_next;
            valid_reg  <= valid_next;
            frames_reg <= frames_next;
            bytes_reg  <= bytes_next;
        end
    end

    always_comb
    begin
        p_clamp = (seek_percent > {1'b0, SEEK_MAX}) ? SEEK_MAX : seek_percent[14:0];
        a_in    = (p_clamp[14:8] > TOC_LAST) ? TOC_LAST : p_clamp[14:8];
        f_in    = 9'(p_clamp - {a_in, 8'h00});
        a_nxt   = (a_reg == TOC_LAST) ? a_reg : a_reg + TOC_AW'(1);
        ram_raddr = cmd.seek_start ? a_in : a_nxt;
        fa_sel  = flags_reg[2] ? ram_rdata : LIN_TOC[a_reg];
        if (a_reg == TOC_LAST)
        begin
            fb_sel = FB_END;
        end
        else
        begin
            fb_sel = {1'b0, flags_reg[2] ? ram_rdata : LIN_TOC[a_nxt]};
        end
        diff   = fb_sel - {1'b0, fa_reg};
        part   = diff * f_reg;
        fx_sum = {2'b00, fa_reg, 8'h00} + part;
        big    = 49'(fx_reg) * 49'(bytes_reg);
    end

    xvbr_ram #(
        .WIDTH (8),
        .DEPTH (TOC_ENTRIES)
    ) u_toc_ram (
        .clk   (clk),
        .we    (cmd.toc_write),
        .waddr (pos_eff),
        .wdata (data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.toc_write)
        begin
            prev_toc_reg <= data_byte;
        end
        if (cmd.seek_start)
        begin
            a_reg <= a_in;
            f_reg <= f_in;
        end
        if (cmd.seek_fa)
        begin
            fa_reg <= fa_sel;
        end
        if (cmd.seek_fx)
        begin
            fx_reg <= fx_sum[16:0];
        end
        if (cmd.fin)
        begin
            kind_reg   <= RESULT_VERDICT;
            ok_reg     <= valid_next;
            fcount_reg <= valid_next ? frames_next[30:0] : '0;
            sbytes_reg <= valid_next ? bytes_next : '0;
            offset_reg <= '0;
        end
        else if (cmd.seek_done)
        begin
            kind_reg   <= RESULT_SEEK;
            ok_reg     <= valid_reg;
            fcount_reg <= valid_reg ? frames_reg[30:0] : '0;
            sbytes_reg <= valid_reg ? bytes_reg : '0;
            offset_reg <= valid_reg ? big[47:16] : '0;
        end
    end

    assign result_kind  = kind_reg;
    assign header_ok    = ok_reg;
    assign frame_count  = fcount_reg;
    assign stream_bytes = sbytes_reg;
    assign seek_offset  = offset_reg;

endmodule

`default_nettype wire

@@ verif/xing_vbr_header_parse_and_seek_test.sv @@
// Self-checking testbench for the Xing VBR header parser with table-of-contents seek.
`default_nettype none

module xing_vbr_header_parse_and_seek_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xvbr_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;

    typedef enum logic [2:0]
    {
        P_IDLE,
        P_HDR,
        P_SIDE,
        P_TAG,
        P_FLAGS,
        P_FRAMES,
        P_BYTES,
        P_TOC
    } parse_phase_t;

    typedef enum int
    {
        TOC_RAMP,
        TOC_STEEP,
        TOC_DIP,
        TOC_FLAT_ZERO
    } toc_shape_t;

    typedef struct
    {
        logic        kind;
        logic        ok;
        logic [30:0] frames;
        logic [31:0] nbytes;
        logic [31:0] offset;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic        frame_start;
    logic [7:0]  data_byte;
    logic [15:0] seek_percent;
    logic        done;
    logic        result_kind;
    logic        header_ok;
    logic [30:0] frame_count;
    logic [31:0] stream_bytes;
    logic [31:0] seek_offset;

    xing_vbr_header_parse_and_seek dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .frame_start  (frame_start),
        .data_byte    (data_byte),
        .seek_percent (seek_percent),
        .done         (done),
        .result_kind  (result_kind),
        .header_ok    (header_ok),
        .frame_count  (frame_count),
        .stream_bytes (stream_bytes),
        .seek_offset  (seek_offset)
    );

    answer_t      pending_answers[$];
    answer_t      head;
    int           failures = 0;
    int           counted_items = 0;
    int           idle_pct = 0;
    int           cycles = 0;
    bit           start_high = 0;

    parse_phase_t phase_now = P_IDLE;
    int unsigned  pos = 0;
    bit           mpeg1_bit = 0;
    logic [1:0]   chan_mode = '0;
    logic [2:0]   flag_bits = '0;
    logic [31:0]  frames_held = '0;
    logic [31:0]  bytes_held = '0;
    bit           toc_on = 0;
    logic [7:0]   toc_mem [TOC_ENTRIES];
    bit           header_valid = 0;

    logic [7:0]   frame_bytes[$];
    logic [7:0]   toc_plan [TOC_ENTRIES];
    int           tag_at;

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned side_info_len(bit mpeg1, logic [1:0] mode);
        if (mpeg1)
            return 32'((mode != MODE_MONO) ? SKIP_LONG : SKIP_MID);
        return 32'((mode != MODE_MONO) ? SKIP_MID : SKIP_SHORT);
    endfunction

    function automatic int unsigned toc_entry(int unsigned i);
        if (i >= TOC_ENTRIES)
            return 32'(FB_END);
        if (toc_on)
            return 32'(toc_mem[i]);
        return (i * 256) / TOC_ENTRIES;
    endfunction

    task automatic post_answer(logic kind, logic [31:0] offset);
        answer_t a;
        a.kind   = kind;
        a.ok     = header_valid;
        a.frames = header_valid ? frames_held[30:0] : 31'd0;
        a.nbytes = header_valid ? bytes_held : 32'd0;
        a.offset = offset;
        pending_answers.push_back(a);
    endtask

    task automatic close_parse(bit accept);
        header_valid = accept;
        phase_now = P_IDLE;
        pos = 0;
        post_answer(RESULT_VERDICT, 32'd0);
    endtask

    task automatic after_counts(bit bytes_done);
        pos = 0;
        if (!bytes_done && flag_bits[1])
            phase_now = P_BYTES;
        else if (flag_bits[2])
            phase_now = P_TOC;
        else
            close_parse(1'b1);
    endtask

    task automatic check_frames();
        if (frames_held == 32'd0 || frames_held[31])
            close_parse(1'b0);
        else
            after_counts(1'b0);
    endtask

    task automatic predict_answer(logic act, logic fs, logic [7:0] b, logic [15:0] pct);
        int unsigned p, a, fa, fb, f, fx;
        logic [63:0] prod;
        if (act)
        begin
            prod = '0;
            if (header_valid)
            begin
                p = 32'((pct > {1'b0, SEEK_MAX}) ? {1'b0, SEEK_MAX} : pct);
                a = p >> 8;
                if (a > TOC_ENTRIES - 1)
                    a = TOC_ENTRIES - 1;
                fa = toc_entry(a);
                fb = (a < TOC_ENTRIES - 1) ? toc_entry(a + 1) : 32'(FB_END);
                f = p - a * 256;
                fx = fa * 256 + (fb - fa) * f;
                prod = (64'(fx) * 64'(bytes_held)) >> 16;
            end
            post_answer(RESULT_SEEK, prod[31:0]);
            counted_items++;
            return;
        end
        if (fs)
        begin
            phase_now = P_HDR;
            pos = 0;
            header_valid = 0;
            frames_held = '0;
            bytes_held = '0;
            flag_bits = '0;
            toc_on = 0;
        end
        if (phase_now == P_IDLE)
            return;
        counted_items++;
        case (phase_now)
            P_HDR:
            begin
                if (pos == 1)
                    mpeg1_bit = b[3];
                if (pos == 3)
                    chan_mode = b[7:6];
                pos++;
                if (pos >= 4)
                begin
                    phase_now = P_SIDE;
                    pos = 0;
                end
            end
            P_SIDE:
            begin
                pos++;
                if (pos >= side_info_len(mpeg1_bit, chan_mode))
                begin
                    phase_now = P_TAG;
                    pos = 0;
                end
            end
            P_TAG:
            begin
                if (b != TAG_CHARS[pos])
                    close_parse(1'b0);
                else
                begin
                    pos++;
                    if (pos >= 4)
                    begin
                        phase_now = P_FLAGS;
                        pos = 0;
                    end
                end
            end
            P_FLAGS:
            begin
                pos++;
                if (pos >= 4)
                begin
                    flag_bits = b[2:0];
                    toc_on = b[2];
                    pos = 0;
                    if (flag_bits[0])
                        phase_now = P_FRAMES;
                    else
                        check_frames();
                end
            end
            P_FRAMES:
            begin
                frames_held = {frames_held[23:0], b};
                pos++;
                if (pos >= 4)
                    check_frames();
            end
            P_BYTES:
            begin
                bytes_held = {bytes_held[23:0], b};
                pos++;
                if (pos >= 4)
                    after_counts(1'b1);
            end
            P_TOC:
            begin
                if (pos >= TOC_ENTRIES)
                    close_parse(1'b0);
                else
                begin
                    toc_mem[pos] = b;
                    if (pos > 0 && b < toc_mem[pos - 1])
                        close_parse(1'b0);
                    else
                    begin
                        pos++;
                        if (pos >= TOC_ENTRIES)
                            close_parse(b != 8'd0);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result transaction with no expected answer");
                failures++;
            end
            else
            begin
                head = pending_answers.pop_front();
                compare_field("result_kind", 32'(head.kind), 32'(result_kind));
                compare_field("header_ok", 32'(head.ok), 32'(header_ok));
                compare_field("frame_count", 32'(head.frames), 32'(frame_count));
                compare_field("stream_bytes", head.nbytes, stream_bytes);
                compare_field("seek_offset", head.offset, seek_offset);
            end
        end
    end

    task automatic send_item(logic act, logic fs, logic [7:0] b, logic [15:0] pct);
        start <= 1'b1;
        start_high = 1;
        action <= act;
        frame_start <= fs;
        data_byte <= b;
        seek_percent <= pct;
        do @(posedge clk); while (busy !== 1'b0);
        predict_answer(act, fs, b, pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            start_high = 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_seek(logic [15:0] pct);
        send_item(1'b1, 1'($urandom), 8'($urandom), pct);
    endtask

    task automatic drain_answers();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 0;
        end
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] random_pct();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return 16'($urandom);
        if (r < 80)
            return 16'($urandom_range(0, SEEK_MAX));
        if (r < 90)
            return 16'(256 * $urandom_range(0, TOC_ENTRIES));
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'(SEEK_MAX - 1);
            2: return 16'(SEEK_MAX);
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic make_toc(toc_shape_t shape);
        int unsigned v, lim, k;
        v = (shape == TOC_DIP) ? $urandom_range(2, 8) : $urandom_range(0, 3);
        if (shape == TOC_STEEP)
            v = 0;
        lim = (shape == TOC_STEEP) ? 5 : $urandom_range(0, 4);
        for (int i = 0; i < TOC_ENTRIES; i++)
        begin
            toc_plan[i] = (shape == TOC_FLAT_ZERO) ? 8'd0 : 8'(v);
            v = v + $urandom_range(0, lim);
            if (v > 255)
                v = 255;
        end
        if (shape == TOC_STEEP)
            toc_plan[TOC_ENTRIES - 1] = 8'd255;
        if (shape == TOC_DIP)
        begin
            k = $urandom_range(1, TOC_ENTRIES - 1);
            toc_plan[k] = toc_plan[k - 1] - 8'd1;
        end
    endtask

    task automatic build_frame(bit mpeg1, logic [1:0] mode, logic [2:0] flags,
                               logic [31:0] frames, logic [31:0] nbytes);
        logic [7:0] r;
        frame_bytes.delete();
        frame_bytes.push_back(8'($urandom));
        r = 8'($urandom);
        r[3] = mpeg1;
        frame_bytes.push_back(r);
        frame_bytes.push_back(8'($urandom));
        r = 8'($urandom);
        r[7:6] = mode;
        frame_bytes.push_back(r);
        repeat (side_info_len(mpeg1, mode))
            frame_bytes.push_back(8'($urandom));
        tag_at = frame_bytes.size();
        foreach (TAG_CHARS[k])
            frame_bytes.push_back(TAG_CHARS[k]);
        repeat (3)
            frame_bytes.push_back(8'($urandom));
        r = 8'($urandom);
        r[2:0] = flags;
        frame_bytes.push_back(r);
        if (flags[0])
            for (int k = 3; k >= 0; k--)
                frame_bytes.push_back(frames[8*k +: 8]);
        if (flags[1])
            for (int k = 3; k >= 0; k--)
                frame_bytes.push_back(nbytes[8*k +: 8]);
        if (flags[2])
            foreach (toc_plan[k])
                frame_bytes.push_back(toc_plan[k]);
    endtask

    task automatic corrupt_tag();
        int k;
        k = tag_at + $urandom_range(0, 3);
        frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
    endtask

    task automatic play_frame(int len, bit seek_inside);
        int mid;
        mid = -1;
        if (seek_inside && len > 1)
            mid = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++)
        begin
            if (i == mid)
                send_seek(random_pct());
            send_item(1'b0, i == 0, frame_bytes[i], 16'($urandom));
        end
    endtask

    task automatic test_table_header();
        make_toc(TOC_STEEP);
        build_frame(1'b1, 2'd0, 3'b111, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        play_frame(frame_bytes.size(), 1'b0);
    endtask

    task automatic test_seek_bounds();
        logic [15:0] points [11] = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd12800, 16'd25343,
                                      16'd25344, 16'd25599, 16'd25600, 16'd25601, 16'hFFFF};
        foreach (points[k])
            send_seek(points[k]);
    endtask

    task automatic test_side_info_and_counts();
        build_frame(1'b0, MODE_MONO, 3'b011, 32'd1, $urandom);
        play_frame(frame_bytes.size(), 1'b0);
        send_seek(16'd0);
        send_seek(16'd12345);
        send_seek(SEEK_MAX);
        build_frame(1'b1, MODE_MONO, 3'b001, 32'd200, 32'd0);
        play_frame(frame_bytes.size(), 1'b0);
        send_seek(random_pct());
        make_toc(TOC_RAMP);
        build_frame(1'b0, 2'd1, 3'b101, 32'h0000_1000, 32'd0);
        play_frame(frame_bytes.size(), 1'b0);
        send_seek(16'd20000);
        make_toc(TOC_RAMP);
        build_frame(1'b1, 2'd2, 3'b111, 32'd5000, $urandom);
        play_frame(frame_bytes.size(), 1'b0);
        repeat (3)
            send_seek(random_pct());
    endtask

    task automatic test_rejections();
        build_frame(1'b1, 2'd1, 3'b011, 32'd10, 32'd1000);
        corrupt_tag();
        play_frame(frame_bytes.size(), 1'b0);
        send_seek(16'd12800);
        build_frame(1'b0, 2'd0, 3'b011, 32'd0, 32'd1000);
        play_frame(frame_bytes.size(), 1'b0);
        build_frame(1'b0, 2'd2, 3'b001, 32'h8000_0000, 32'd0);
        play_frame(frame_bytes.size(), 1'b0);
        build_frame(1'b1, MODE_MONO, 3'b110, 32'd77, 32'd1000);
        play_frame(frame_bytes.size(), 1'b0);
        make_toc(TOC_DIP);
        build_frame(1'b1, 2'd0, 3'b111, 32'd99, 32'd4096);
        play_frame(frame_bytes.size(), 1'b0);
        make_toc(TOC_FLAT_ZERO);
        build_frame(1'b0, MODE_MONO, 3'b101, 32'd3, 32'd0);
        play_frame(frame_bytes.size(), 1'b0);
        send_seek(16'd25600);
    endtask

    task automatic test_truncation_and_strays();
        build_frame(1'b1, 2'd3, 3'b011, 32'd42, 32'd123456);
        play_frame(frame_bytes.size() / 2, 1'b1);
        build_frame(1'b0, 2'd1, 3'b011, 32'd42, 32'd123456);
        play_frame(frame_bytes.size(), 1'b1);
        repeat (3)
            send_item(1'b0, 1'b0, 8'($urandom), 16'($urandom));
        send_seek(16'd6400);
    endtask

    task automatic random_scenario();
        int unsigned choice, len;
        bit          mpeg1;
        logic [1:0]  mode;
        logic [2:0]  flags;
        logic [31:0] frames;
        logic [31:0] nbytes;
        toc_shape_t  shape;
        choice = $urandom_range(99);
        if (choice < 12)
        begin
            repeat ($urandom_range(1, 3))
                send_item(1'b0, 1'b0, 8'($urandom), 16'($urandom));
            return;
        end
        if (choice < 30)
        begin
            repeat ($urandom_range(1, 3))
                send_seek(random_pct());
            return;
        end
        mpeg1 = 1'($urandom);
        mode = 2'($urandom);
        flags = ($urandom_range(99) < 85) ? {1'b0, 1'($urandom), 1'b1} : 3'($urandom);
        flags[2] = ($urandom_range(99) < 25);
        choice = $urandom_range(99);
        if (choice < 8)
            frames = 32'd0;
        else if (choice < 16)
            frames = {1'b1, 31'($urandom)};
        else if (choice < 30)
            frames = $urandom_range(1, 16);
        else
            frames = {1'b0, 31'($urandom)};
        nbytes = ($urandom_range(99) < 20) ? $urandom_range(0, 1000) : $urandom;
        choice = $urandom_range(99);
        if (choice < 70)
            shape = TOC_RAMP;
        else if (choice < 80)
            shape = TOC_STEEP;
        else if (choice < 90)
            shape = TOC_DIP;
        else
            shape = TOC_FLAT_ZERO;
        make_toc(shape);
        build_frame(mpeg1, mode, flags, frames, nbytes);
        if ($urandom_range(99) < 8)
            corrupt_tag();
        len = frame_bytes.size();
        if ($urandom_range(99) < 8)
            len = $urandom_range(1, len - 1);
        play_frame(len, $urandom_range(99) < 10);
        repeat ($urandom_range(0, 2))
            send_seek(random_pct());
    endtask

    task automatic test_random_traffic(int sender_idle, int quota);
        int target;
        idle_pct = sender_idle;
        target = counted_items + quota;
        while (counted_items < target)
            random_scenario();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = 1'b0;
        frame_start = 1'b0;
        data_byte = '0;
        seek_percent = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 24;
        test_table_header();
        test_seek_bounds();
        test_side_info_and_counts();
        test_rejections();
        test_truncation_and_strays();
        test_random_traffic(24, 20);
        // Hold off new transactions until every outstanding answer is back.
        drain_answers();
        test_random_traffic(53, 40);
        drain_answers();
        test_random_traffic(0, 40);

        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d expected answers never arrived", pending_answers.size());
            failures++;
        end
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/xvbr_pkg.sv
rtl/core/xvbr_ram.sv
rtl/core/xvbr_ctrl.sv
rtl/core/xvbr_dp.sv
rtl/core/xing_vbr_header_parse_and_seek.sv
verif/xing_vbr_header_parse_and_seek_test.sv
